// ----- rtl/mtpe_pkg.sv -----
// Shared types and codes for the mission transfer protocol engine.
// No dependencies; every other file refers to this package by scoped names.
package mtpe_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_SYSTEM       = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PARTNER_COMP     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RETRIES      = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS    = 4'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]  OWN_SYSTEM_RST    = 8'd1;
  localparam logic [7:0]  PARTNER_COMP_RST  = 8'd190;
  localparam logic [2:0]  MAX_RETRIES_RST   = 3'd5;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd2000;

  // Input kinds
  localparam logic [3:0] KIND_TICK        = 4'd0;
  localparam logic [3:0] KIND_READ        = 4'd1;
  localparam logic [3:0] KIND_WRITE       = 4'd2;
  localparam logic [3:0] KIND_CLEAR       = 4'd3;
  localparam logic [3:0] KIND_SET_CURRENT = 4'd4;
  localparam logic [3:0] KIND_RX_COUNT    = 4'd5;
  localparam logic [3:0] KIND_RX_ITEM     = 4'd6;
  localparam logic [3:0] KIND_RX_ACK      = 4'd7;
  localparam logic [3:0] KIND_RX_REQUEST  = 4'd8;
  localparam logic [3:0] KIND_RX_CURRENT  = 4'd9;
  localparam logic [3:0] KIND_RX_REACHED  = 4'd10;

  // Outgoing message kinds
  localparam logic [2:0] SEND_NONE         = 3'd0;
  localparam logic [2:0] SEND_REQUEST_LIST = 3'd1;
  localparam logic [2:0] SEND_REQUEST_ITEM = 3'd2;
  localparam logic [2:0] SEND_COUNT        = 3'd3;
  localparam logic [2:0] SEND_ITEM         = 3'd4;
  localparam logic [2:0] SEND_CLEAR_ALL    = 3'd5;
  localparam logic [2:0] SEND_SET_CURRENT  = 3'd6;
  localparam logic [2:0] SEND_ACK          = 3'd7;

  // Status events
  localparam logic [3:0] EV_NONE            = 4'd0;
  localparam logic [3:0] EV_DONE            = 4'd1;
  localparam logic [3:0] EV_RETRYING        = 4'd2;
  localparam logic [3:0] EV_TIMED_OUT       = 4'd3;
  localparam logic [3:0] EV_REJECTED        = 4'd4;
  localparam logic [3:0] EV_REFUSED         = 4'd5;
  localparam logic [3:0] EV_ITEM_STORED     = 4'd6;
  localparam logic [3:0] EV_CURRENT_CHANGED = 4'd7;
  localparam logic [3:0] EV_REACHED         = 4'd8;

  // Transaction phase
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_GET_LIST    = 3'd1,
    PH_GET_ITEMS   = 3'd2,
    PH_SEND_LIST   = 3'd3,
    PH_SEND_ITEMS  = 3'd4,
    PH_CLEAR_LIST  = 3'd5,
    PH_SET_CURRENT = 3'd6
  } phase_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  src_system;
    logic [7:0]  src_component;
    logic [15:0] seq;
    logic [15:0] count;
    logic [7:0]  ack_type;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  send_kind;
    logic [15:0] send_seq;
    logic [15:0] send_count;
    logic [3:0]  event_res;
    logic [15:0] event_seq;
    logic [2:0]  retries_left;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  own_system;
    logic [7:0]  partner_component;
    logic [2:0]  max_retries;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

// ----- rtl/mtpe_cfg.sv -----
// Configuration register file of the mission transfer protocol engine.
// Depends on mtpe_pkg for the register indexes, reset values and cfg_t.
module mtpe_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data,
  output mtpe_pkg::cfg_t                      cfg
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_system        <= mtpe_pkg::OWN_SYSTEM_RST;
      cfg.partner_component <= mtpe_pkg::PARTNER_COMP_RST;
      cfg.max_retries       <= mtpe_pkg::MAX_RETRIES_RST;
      cfg.timeout_ticks     <= mtpe_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mtpe_pkg::REG_OWN_SYSTEM:    cfg.own_system        <= cfg_data[7:0];
        mtpe_pkg::REG_PARTNER_COMP:  cfg.partner_component <= cfg_data[7:0];
        mtpe_pkg::REG_MAX_RETRIES:   cfg.max_retries       <= cfg_data[2:0];
        mtpe_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/mtpe_core.sv -----
// Protocol state and per-transfer decision logic of the mission engine.
// Depends on mtpe_pkg for codes, phase_t, in_item_t, out_item_t and cfg_t.
module mtpe_core (
  input  logic                 clk,
  input  logic                 rst,
  input  mtpe_pkg::cfg_t       cfg,
  input  logic                 in_fire,
  input  mtpe_pkg::in_item_t   in_item,
  output mtpe_pkg::out_item_t  result
);

  mtpe_pkg::phase_t phase, phase_next;
  logic [15:0] index, index_next;
  logic [15:0] item_count, item_count_next;
  logic [2:0]  retries, retries_next;
  logic [7:0]  peer_system, peer_system_next;
  logic [7:0]  peer_component, peer_component_next;
  logic [15:0] timer, timer_next;
  logic        timer_running, timer_running_next;

  // Shared decode
  logic [15:0] tick_count;
  logic        tick_expire;
  logic        has_retry;
  logic        from_peer;
  logic [15:0] index_inc;
  logic        item_ok;
  logic        ack_ok;
  logic        request_ok;

  assign tick_count  = (timer != 16'hFFFF) ? timer + 16'd1 : timer;
  assign tick_expire = timer_running && !(tick_count < cfg.timeout_ticks);
  assign has_retry   = (retries != 3'd0);
  assign from_peer   = (in_item.src_system == peer_system) &&
                       (in_item.src_component == peer_component);
  assign index_inc   = index + 16'd1;
  assign item_ok     = (phase == mtpe_pkg::PH_GET_ITEMS) && from_peer &&
                       (in_item.seq == index);
  assign ack_ok      = from_peer && (in_item.ack_type == 8'd0) &&
                       ((phase == mtpe_pkg::PH_SEND_LIST) ||
                        (phase == mtpe_pkg::PH_SEND_ITEMS)) &&
                       (index == item_count - 16'd1);
  assign request_ok  = from_peer &&
                       (((phase == mtpe_pkg::PH_SEND_LIST) && (in_item.seq == 16'd0)) ||
                        ((phase == mtpe_pkg::PH_SEND_ITEMS) &&
                         ((in_item.seq == index) ||
                          ({1'b0, in_item.seq} == {1'b0, index} + 17'd1))));

  // Next state
  always_comb begin
    phase_next          = phase;
    index_next          = index;
    item_count_next     = item_count;
    retries_next        = retries;
    peer_system_next    = peer_system;
    peer_component_next = peer_component;
    timer_next          = timer;
    timer_running_next  = timer_running;
    unique case (in_item.kind)
      mtpe_pkg::KIND_TICK: begin
        if (timer_running) begin
          if (!tick_expire) begin
            timer_next = tick_count;
          end else if (has_retry) begin
            retries_next = retries - 3'd1;
            timer_next   = 16'd0;
          end else begin
            timer_running_next  = 1'b0;
            timer_next          = 16'd0;
            phase_next          = mtpe_pkg::PH_IDLE;
            item_count_next     = 16'd0;
            index_next          = 16'd0;
            peer_system_next    = 8'd0;
            peer_component_next = 8'd0;
          end
        end
      end
      mtpe_pkg::KIND_READ, mtpe_pkg::KIND_CLEAR, mtpe_pkg::KIND_WRITE,
      mtpe_pkg::KIND_SET_CURRENT: begin
        if (phase == mtpe_pkg::PH_IDLE &&
            !(in_item.kind == mtpe_pkg::KIND_WRITE && in_item.count == 16'd0) &&
            !(in_item.kind == mtpe_pkg::KIND_SET_CURRENT &&
              !(in_item.seq < in_item.count))) begin
          timer_next          = 16'd0;
          timer_running_next  = 1'b1;
          retries_next        = cfg.max_retries;
          peer_system_next    = cfg.own_system;
          peer_component_next = cfg.partner_component;
          index_next          = 16'd0;
          if (in_item.kind == mtpe_pkg::KIND_READ) begin
            phase_next = mtpe_pkg::PH_GET_LIST;
          end else if (in_item.kind == mtpe_pkg::KIND_CLEAR) begin
            phase_next = mtpe_pkg::PH_CLEAR_LIST;
          end else if (in_item.kind == mtpe_pkg::KIND_WRITE) begin
            phase_next      = mtpe_pkg::PH_SEND_LIST;
            item_count_next = in_item.count;
          end else begin
            phase_next = mtpe_pkg::PH_SET_CURRENT;
            index_next = in_item.seq;
          end
        end
      end
      mtpe_pkg::KIND_RX_COUNT: begin
        if (phase == mtpe_pkg::PH_GET_LIST && from_peer) begin
          retries_next = cfg.max_retries;
          timer_next   = 16'd0;
          if (in_item.count != 16'd0) begin
            timer_running_next = 1'b1;
            item_count_next    = in_item.count;
            index_next         = 16'd0;
            phase_next         = mtpe_pkg::PH_GET_ITEMS;
          end else begin
            timer_running_next  = 1'b0;
            phase_next          = mtpe_pkg::PH_IDLE;
            item_count_next     = 16'd0;
            index_next          = 16'd0;
            peer_system_next    = 8'd0;
            peer_component_next = 8'd0;
          end
        end
      end
      mtpe_pkg::KIND_RX_ITEM: begin
        if (item_ok) begin
          retries_next = cfg.max_retries;
          timer_next   = 16'd0;
          if (index_inc < item_count) begin
            timer_running_next = 1'b1;
            index_next         = index_inc;
          end else begin
            timer_running_next  = 1'b0;
            phase_next          = mtpe_pkg::PH_IDLE;
            item_count_next     = 16'd0;
            index_next          = 16'd0;
            peer_system_next    = 8'd0;
            peer_component_next = 8'd0;
          end
        end
      end
      mtpe_pkg::KIND_RX_ACK: begin
        if (ack_ok) begin
          // finished write: start the read-back
          timer_next          = 16'd0;
          timer_running_next  = 1'b1;
          retries_next        = cfg.max_retries;
          phase_next          = mtpe_pkg::PH_GET_LIST;
          index_next          = 16'd0;
          peer_system_next    = cfg.own_system;
          peer_component_next = cfg.partner_component;
        end else if (from_peer && phase == mtpe_pkg::PH_CLEAR_LIST) begin
          timer_running_next = 1'b0;
          timer_next         = 16'd0;
          phase_next         = mtpe_pkg::PH_IDLE;
        end
      end
      mtpe_pkg::KIND_RX_REQUEST: begin
        if (request_ok) begin
          timer_next         = 16'd0;
          timer_running_next = 1'b1;
          retries_next       = cfg.max_retries;
          if (in_item.seq < item_count) begin
            phase_next = mtpe_pkg::PH_SEND_ITEMS;
            index_next = in_item.seq;
          end
        end
      end
      mtpe_pkg::KIND_RX_CURRENT: begin
        if (in_item.src_system == cfg.own_system &&
            phase == mtpe_pkg::PH_SET_CURRENT) begin
          timer_running_next = 1'b0;
          timer_next         = 16'd0;
          phase_next         = mtpe_pkg::PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  // Result of this transfer
  always_comb begin
    result              = '0;
    result.retries_left = retries_next;
    unique case (in_item.kind)
      mtpe_pkg::KIND_TICK: begin
        if (tick_expire) begin
          result.event_seq = index;
          if (has_retry) begin
            result.event_res = mtpe_pkg::EV_RETRYING;
            unique case (phase)
              mtpe_pkg::PH_GET_LIST: result.send_kind = mtpe_pkg::SEND_REQUEST_LIST;
              mtpe_pkg::PH_GET_ITEMS: begin
                result.send_kind = mtpe_pkg::SEND_REQUEST_ITEM;
                result.send_seq  = index;
              end
              mtpe_pkg::PH_SEND_LIST: begin
                result.send_kind  = mtpe_pkg::SEND_COUNT;
                result.send_count = item_count;
              end
              mtpe_pkg::PH_SEND_ITEMS: begin
                if (index < item_count) begin
                  result.send_kind = mtpe_pkg::SEND_ITEM;
                  result.send_seq  = index;
                end
              end
              mtpe_pkg::PH_CLEAR_LIST: result.send_kind = mtpe_pkg::SEND_CLEAR_ALL;
              mtpe_pkg::PH_SET_CURRENT: begin
                result.send_kind = mtpe_pkg::SEND_SET_CURRENT;
                result.send_seq  = index;
              end
              default: ;
            endcase
          end else begin
            result.event_res = mtpe_pkg::EV_TIMED_OUT;
          end
        end
      end
      mtpe_pkg::KIND_READ: begin
        if (phase == mtpe_pkg::PH_IDLE) result.send_kind = mtpe_pkg::SEND_REQUEST_LIST;
        else result.event_res = mtpe_pkg::EV_REFUSED;
      end
      mtpe_pkg::KIND_WRITE: begin
        if (phase != mtpe_pkg::PH_IDLE) begin
          result.event_res = mtpe_pkg::EV_REFUSED;
        end else if (in_item.count == 16'd0) begin
          result.send_kind = mtpe_pkg::SEND_CLEAR_ALL;
        end else begin
          result.send_kind  = mtpe_pkg::SEND_COUNT;
          result.send_count = in_item.count;
        end
      end
      mtpe_pkg::KIND_CLEAR: begin
        if (phase == mtpe_pkg::PH_IDLE) result.send_kind = mtpe_pkg::SEND_CLEAR_ALL;
        else result.event_res = mtpe_pkg::EV_REFUSED;
      end
      mtpe_pkg::KIND_SET_CURRENT: begin
        if (phase == mtpe_pkg::PH_IDLE && in_item.seq < in_item.count) begin
          result.send_kind = mtpe_pkg::SEND_SET_CURRENT;
          result.send_seq  = in_item.seq;
        end else begin
          result.event_res = mtpe_pkg::EV_REFUSED;
          result.event_seq = in_item.seq;
        end
      end
      mtpe_pkg::KIND_RX_COUNT: begin
        if (phase == mtpe_pkg::PH_GET_LIST && from_peer) begin
          if (in_item.count != 16'd0) result.send_kind = mtpe_pkg::SEND_REQUEST_ITEM;
          else result.event_res = mtpe_pkg::EV_DONE;
        end else begin
          result.event_res = mtpe_pkg::EV_REJECTED;
        end
      end
      mtpe_pkg::KIND_RX_ITEM: begin
        result.event_seq = in_item.seq;
        if (item_ok) begin
          if (index_inc < item_count) begin
            result.event_res = mtpe_pkg::EV_ITEM_STORED;
            result.send_kind = mtpe_pkg::SEND_REQUEST_ITEM;
            result.send_seq  = index_inc;
          end else begin
            result.event_res = mtpe_pkg::EV_DONE;
            result.send_kind = mtpe_pkg::SEND_ACK;
          end
        end else begin
          result.event_res = mtpe_pkg::EV_REJECTED;
        end
      end
      mtpe_pkg::KIND_RX_ACK: begin
        if (ack_ok) begin
          result.event_res = mtpe_pkg::EV_DONE;
          result.send_kind = mtpe_pkg::SEND_REQUEST_LIST;
        end else if (from_peer && phase == mtpe_pkg::PH_CLEAR_LIST) begin
          result.event_res = mtpe_pkg::EV_DONE;
        end else begin
          result.event_res = mtpe_pkg::EV_REJECTED;
        end
      end
      mtpe_pkg::KIND_RX_REQUEST: begin
        if (request_ok) begin
          if (in_item.seq < item_count) begin
            result.send_kind = mtpe_pkg::SEND_ITEM;
            result.send_seq  = in_item.seq;
          end
        end else begin
          result.event_res = mtpe_pkg::EV_REJECTED;
          result.event_seq = in_item.seq;
        end
      end
      mtpe_pkg::KIND_RX_CURRENT: begin
        if (in_item.src_system == cfg.own_system) begin
          result.event_res = mtpe_pkg::EV_CURRENT_CHANGED;
          result.event_seq = in_item.seq;
        end
      end
      mtpe_pkg::KIND_RX_REACHED: begin
        if (in_item.src_system == cfg.own_system) begin
          result.event_res = mtpe_pkg::EV_REACHED;
          result.event_seq = in_item.seq;
        end
      end
      default: ;
    endcase
  end

  // State registers, updated once per accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mtpe_pkg::PH_IDLE;
      index          <= 16'd0;
      item_count     <= 16'd0;
      retries        <= 3'd0;
      peer_system    <= 8'd0;
      peer_component <= 8'd0;
      timer          <= 16'd0;
      timer_running  <= 1'b0;
    end else if (in_fire) begin
      phase          <= phase_next;
      index          <= index_next;
      item_count     <= item_count_next;
      retries        <= retries_next;
      peer_system    <= peer_system_next;
      peer_component <= peer_component_next;
      timer          <= timer_next;
      timer_running  <= timer_running_next;
    end
  end

`ifndef ASSERT_OFF
  // Out of a transaction the timeout counter never runs
  assert property (@(posedge clk) disable iff (rst)
    (phase == mtpe_pkg::PH_IDLE) |-> !timer_running)
    else $error("timer running while idle");

  // A timeout without retries always lands in idle with cleared peers
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_item.kind == mtpe_pkg::KIND_TICK && tick_expire && !has_retry)
    |=> (phase == mtpe_pkg::PH_IDLE && peer_system == 8'd0 && item_count == 16'd0))
    else $error("give-up did not clear the transaction");

  // The phase register only ever holds a defined phase
  assert property (@(posedge clk) disable iff (rst)
    phase <= mtpe_pkg::PH_SET_CURRENT)
    else $error("phase register out of range");
`endif

endmodule

// ----- rtl/mtpe_out_buf.sv -----
// Result register with a skid stage for the mission engine output channel.
// Depends on mtpe_pkg for out_item_t.
module mtpe_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mtpe_pkg::out_item_t  push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mtpe_pkg::out_item_t  out_data
);

  logic                skid_valid;
  mtpe_pkg::out_item_t skid_data;
  logic                advance;

  // The output slot can take a new result when empty or being taken
  assign advance = !out_valid || !out_stall;
  assign full    = skid_valid;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (advance) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef ASSERT_OFF
  // The skid stage only fills behind a held result
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data while output is empty");

  // A transfer arriving at a stalled full output lands in the skid stage
  assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && out_stall) |=> skid_valid)
    else $error("result lost on stalled output");

  // No transfer is taken while the skid stage is occupied
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("push into full buffer");
`endif

endmodule

// ----- rtl/mission_transfer_protocol_engine.sv -----
// Top level of the mission transfer protocol engine.
// Depends on mtpe_pkg, mtpe_cfg, mtpe_core and mtpe_out_buf.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one tick, local
//   command or received message per transfer. Output channel (out_valid /
//   out_stall / out_data) returns exactly one result per input: the message
//   to send, its sequence and count, a status event and the retries left.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   partner ids, retry limit and timeout; write only while no result is
//   outstanding. cfg_ready is always high.
// Timing:
//   An input is decided in the cycle it is accepted; its result is registered in
//   the output slot, or in the skid stage while the output is stalled. One input
//   per cycle is taken while in_stall is low; mtpe_core updates state per input.
// Reset (rst, synchronous): phase idle, all counters and peers cleared,
//   configuration back to its defaults, output empty.
// Stalls: a two-entry result buffer absorbs one extra result while out_stall
//   is high; in_stall rises once both entries are occupied.
module mission_transfer_protocol_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mtpe_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mtpe_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtpe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data
);

  mtpe_pkg::cfg_t      cfg;
  mtpe_pkg::out_item_t result;
  logic                in_fire;
  logic                buf_full;

  // Accept handshake
  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  mtpe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mtpe_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_fire (in_fire),
    .in_item (in_data),
    .result  (result)
  );

  mtpe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
